### hdl/gab_pkg.sv
// Package for the gamma-2 alpha blend unit: shared constants and pipeline payload types.
// No dependencies; imported by gab_front, gab_root_stage and gamma2_alpha_blend_unit.
`timescale 1ns / 1ps
`default_nettype none

package gab_pkg;

    localparam int NUM_CHAN  = 3;
    localparam int ROOT_BITS = 8;
    localparam int LIN_W     = 26;   // 4 * (f^2*fa + b^2*(255-fa)) stays below 2^26

    localparam logic [7:0]  CHAN_MAX  = 8'd255;
    localparam logic [15:0] ALPHA_RND = 16'd127;

    typedef logic [LIN_W-1:0] t_lin;

    typedef struct packed {
        t_lin [NUM_CHAN-1:0]                 y;      // 4X per colour channel
        logic [NUM_CHAN-1:0][ROOT_BITS-1:0] root;   // rounded root, built MSB first
        logic [7:0]                          alpha;  // finished composite alpha
    } t_work;

endpackage

`default_nettype wire

### hdl/gab_if.sv
// Stream interfaces for the blend unit: input pixel pair and blended output pixel.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface gab_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] fore_red;
    logic [7:0] fore_green;
    logic [7:0] fore_blue;
    logic [7:0] fore_alpha;
    logic [7:0] back_red;
    logic [7:0] back_green;
    logic [7:0] back_blue;
    logic [7:0] back_alpha;

    modport source (
        output valid, fore_red, fore_green, fore_blue, fore_alpha,
               back_red, back_green, back_blue, back_alpha,
        input  ready
    );
    modport sink (
        input  valid, fore_red, fore_green, fore_blue, fore_alpha,
               back_red, back_green, back_blue, back_alpha,
        output ready
    );
endinterface

interface gab_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

`default_nettype wire

### hdl/gab_front.sv
// Front end of the blend pipeline: squares, alpha weighting, 4X sum and composite alpha.
// Three register stages; depends on gab_pkg and gab_if.
`timescale 1ns / 1ps
`default_nettype none

module gab_front
    import gab_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gab_pix_in_if.sink  i_pix,
    input  wire logic   i_en_next,
    output logic        o_valid,
    output t_work       o_work
);

    logic [NUM_CHAN-1:0][7:0] w_fore;
    logic [NUM_CHAN-1:0][7:0] w_back;

    logic w_en1, w_en2, w_en3;

    // stage 1
    logic                      r1_valid;
    logic [NUM_CHAN-1:0][15:0] r1_f2, n1_f2;
    logic [NUM_CHAN-1:0][15:0] r1_b2, n1_b2;
    logic [7:0]                r1_fa, r1_nfa, n1_nfa;
    logic [15:0]               r1_num, n1_num;
    logic                      r1_zero;
    logic [16:0]               w1_num;

    // stage 2
    logic                      r2_valid;
    logic [NUM_CHAN-1:0][23:0] r2_p1, n2_p1;
    logic [NUM_CHAN-1:0][23:0] r2_p2, n2_p2;
    logic [7:0]                r2_alpha, n2_alpha;
    logic                      r2_zero;
    logic [15:0]               w2_rnd;
    logic [16:0]               w2_quot;

    // stage 3
    logic                      r3_valid;
    t_work                     r3_work, n3_work;
    logic [23:0]               w3_sum [NUM_CHAN];

    assign w_fore = {i_pix.fore_blue, i_pix.fore_green, i_pix.fore_red};
    assign w_back = {i_pix.back_blue, i_pix.back_green, i_pix.back_red};

    // a stage advances when empty or when the next one advances
    assign w_en3       = !r3_valid || i_en_next;
    assign w_en2       = !r2_valid || w_en3;
    assign w_en1       = !r1_valid || w_en2;
    assign i_pix.ready = w_en1;

    always_comb begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            n1_f2[ch] = {8'd0, w_fore[ch]} * {8'd0, w_fore[ch]};
            n1_b2[ch] = {8'd0, w_back[ch]} * {8'd0, w_back[ch]};
        end
        n1_nfa = CHAN_MAX - i_pix.fore_alpha;
        w1_num = ({1'b0, i_pix.fore_alpha, 8'd0} - {9'd0, i_pix.fore_alpha})
               + ({9'd0, i_pix.back_alpha} * {9'd0, n1_nfa});
        n1_num = w1_num[15:0];
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            n2_p1[ch] = {8'd0, r1_f2[ch]} * {16'd0, r1_fa};
            n2_p2[ch] = {8'd0, r1_b2[ch]} * {16'd0, r1_nfa};
        end
        // round half up of num/255, then exact divide by 255 via add-and-shift
        w2_rnd   = r1_num + ALPHA_RND;
        w2_quot  = {1'b0, w2_rnd} + 17'd1 + {9'd0, w2_rnd[15:8]};
        n2_alpha = w2_quot[15:8];
    end

    always_comb begin
        n3_work       = '0;
        n3_work.alpha = r2_alpha;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            w3_sum[ch] = r2_p1[ch] + r2_p2[ch];
            // both alphas clear: a zero root yields the all-zero pixel
            n3_work.y[ch] = r2_zero ? '0 : {w3_sum[ch], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (w_en1) r1_valid <= i_pix.valid;
            if (w_en2) r2_valid <= r1_valid;
            if (w_en3) r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_f2   <= n1_f2;
            r1_b2   <= n1_b2;
            r1_fa   <= i_pix.fore_alpha;
            r1_nfa  <= n1_nfa;
            r1_num  <= n1_num;
            r1_zero <= (i_pix.fore_alpha == 8'd0) && (i_pix.back_alpha == 8'd0);
        end
        if (w_en2) begin
            r2_p1    <= n2_p1;
            r2_p2    <= n2_p2;
            r2_alpha <= n2_alpha;
            r2_zero  <= r1_zero;
        end
        if (w_en3) begin
            r3_work <= n3_work;
        end
    end

    assign o_valid = r3_valid;
    assign o_work  = r3_work;

endmodule

`default_nettype wire

### hdl/gab_root_stage.sv
// One bit of the rounded square root for all colour channels, one register stage.
// Keeps the candidate bit when 255*(2c-1)^2 <= 4X; depends on gab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gab_root_stage
    import gab_pkg::*;
#(
    parameter int BIT = 7
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_work i_work,
    output logic       o_en,
    input  wire logic  i_en_next,
    output logic       o_valid,
    output t_work      o_work
);

    logic  r_valid;
    t_work r_work, n_work;

    logic [ROOT_BITS-1:0] w_cand [NUM_CHAN];
    logic [ROOT_BITS:0]   w_odd  [NUM_CHAN];
    logic [2*ROOT_BITS+1:0] w_sq [NUM_CHAN];
    t_lin                 w_thr  [NUM_CHAN];

    assign o_en = !r_valid || i_en_next;

    always_comb begin
        n_work = i_work;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            w_cand[ch] = i_work.root[ch] | (ROOT_BITS'(1) << BIT);
            w_odd[ch]  = {w_cand[ch], 1'b0} - (ROOT_BITS+1)'(1);
            w_sq[ch]   = {{(ROOT_BITS+1){1'b0}}, w_odd[ch]}
                       * {{(ROOT_BITS+1){1'b0}}, w_odd[ch]};
            // 255 * sq as shift and subtract
            w_thr[ch]  = (LIN_W'(w_sq[ch]) << 8) - LIN_W'(w_sq[ch]);
            if (w_thr[ch] <= i_work.y[ch]) begin
                n_work.root[ch] = w_cand[ch];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

`default_nettype wire

### hdl/gamma2_alpha_blend_unit.sv
// Gamma-2 alpha blend unit: RGBA8 foreground over RGBA8 background, one pixel out per pair.
// Pipeline: 3 front-end stages (squares, weighting, sum) and 8 root stages, one bit each.
// Throughput one transaction per cycle when not stalled; every stage holds under back-pressure
// and empty stages fill while the output is stalled. The last root stage is the output register.
// Reset (synchronous, active low) clears only the stage valid bits.
`timescale 1ns / 1ps
`default_nettype none

module gamma2_alpha_blend_unit
    import gab_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    gab_pix_in_if.sink   i_pix,
    gab_pix_out_if.source o_pix
);

    logic  w_valid [ROOT_BITS+1];
    logic  w_en    [ROOT_BITS+1];
    t_work w_work  [ROOT_BITS+1];

    gab_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .i_en_next (w_en[0]),
        .o_valid   (w_valid[0]),
        .o_work    (w_work[0])
    );

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_root
        gab_root_stage #(
            .BIT (ROOT_BITS - 1 - g)
        ) u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (w_valid[g]),
            .i_work    (w_work[g]),
            .o_en      (w_en[g]),
            .i_en_next (w_en[g+1]),
            .o_valid   (w_valid[g+1]),
            .o_work    (w_work[g+1])
        );
    end

    assign w_en[ROOT_BITS] = o_pix.ready;

    assign o_pix.valid     = w_valid[ROOT_BITS];
    assign o_pix.out_red   = w_work[ROOT_BITS].root[0];
    assign o_pix.out_green = w_work[ROOT_BITS].root[1];
    assign o_pix.out_blue  = w_work[ROOT_BITS].root[2];
    assign o_pix.out_alpha = w_work[ROOT_BITS].alpha;

endmodule

`default_nettype wire
